/* hw/rtl/assembly_source_tokenizer_macros.svh */
// Assertion macros used by the tokenizer top level.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, including while reset is held.
`define ASTOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/astok_pkg.sv */
// Types, character codes and a helper function of the assembly source tokenizer.
package astok_pkg;

  localparam int unsigned LINE_BITS  = 32;
  localparam int unsigned LINE_OUT_W = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned TDATA_W    = 40;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOT  = 1'b1
  } opcode_e;

  typedef enum logic {
    EV_APPEND = 1'b0,
    EV_END    = 1'b1
  } event_kind_e;

  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LOW_R  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LOW_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic                 in_quotes;
    logic                 in_comment;
    logic                 esc_pending;
    logic                 token_open;
    logic [LINE_BITS-1:0] line;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RST = '{
    in_quotes:   1'b0,
    in_comment:  1'b0,
    esc_pending: 1'b0,
    token_open:  1'b0,
    line:        LINE_BITS'(1)
  };

  // The events of one input item; all of them carry the same line.
  typedef struct packed {
    logic                 two;
    event_kind_e          kind0;
    logic [CHAR_W-1:0]    char0;
    event_kind_e          kind1;
    logic [CHAR_W-1:0]    char1;
    logic [LINE_BITS-1:0] line;
  } ev_rec_t;

  typedef struct packed {
    logic       has_event;
    ev_rec_t    rec;
    tok_state_t nxt;
  } step_res_t;

  function automatic logic [CHAR_W-1:0] translate_escape(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    case (c)
      CH_LOW_N: r = CH_LF;
      CH_LOW_R: r = CH_CR;
      CH_LOW_T: r = CH_TAB;
      CH_LOW_B: r = CH_BS;
      CH_ZERO:  r = CH_NUL;
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/assembly_source_tokenizer.sv */
// Top level of the assembly source tokenizer: input register, decode, event queue.
// Path: an accepted item is held in the input register, decoded combinationally and
// written into the event queue; its first event is offered on the output from the queue head.
// Throughput: one item per cycle while each item makes at most one event and the output is
// ready; an item with two events holds its queue entry until both events are taken.
// Reset (rst_ni low, asynchronous): the tokenizer state returns to line 1, nothing open.
`include "assembly_source_tokenizer_macros.svh"

module assembly_source_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] char_code
  input  logic                          s_axis_tuser,  // [0] opcode
  // Token events.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [astok_pkg::TDATA_W-1:0] m_axis_tdata,  // [7:0] char_value, [39:8] line_number
  output logic                          m_axis_tuser,  // [0] event_kind
  output logic                          m_axis_tlast   // last_of_run
);
  import astok_pkg::*;

  // The input register holds one item until the event queue has room for its events.
  // The queue has two entries, each holding all events of one item, so the input side
  // never waits on the output ready in the same cycle.
  logic              in_valid_q, in_valid_d;
  opcode_e           in_op_q;
  logic [CHAR_W-1:0] in_char_q;

  tok_state_t        state_q, state_d;
  step_res_t         step_res;

  ev_rec_t           rec_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              sel_q, sel_d;

  logic              s_fire;
  logic              fire;
  logic              push;
  logic              pop;
  logic              m_fire;
  ev_rec_t           head;

  // The item in the input register is decoded when at least one queue entry is free.
  assign fire          = in_valid_q && (cnt_q != 2'd2);
  assign s_axis_tready = !in_valid_q || (cnt_q != 2'd2);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  astok_step u_step (
    .st_i   (state_q),
    .op_i   (in_op_q),
    .char_i (in_char_q),
    .res_o  (step_res)
  );

  assign push = fire && step_res.has_event;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  assign state_d = fire ? step_res.nxt : state_q;

  // Output side: the head entry is shown one event at a time; sel_q picks the second
  // event of an entry that has two.
  assign head          = rec_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tuser  = sel_q ? head.kind1 : head.kind0;
  assign m_axis_tdata  = {LINE_OUT_W'(head.line), (sel_q ? head.char1 : head.char0)};
  assign m_axis_tlast  = sel_q || !head.two;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign pop           = m_fire && m_axis_tlast;

  always_comb begin
    sel_d = sel_q;
    if (m_fire) begin
      sel_d = !m_axis_tlast;
    end
  end

  assign wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
  assign cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= TOK_STATE_RST;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
      sel_q      <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      sel_q      <= sel_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q   <= opcode_e'(s_axis_tuser);
      in_char_q <= s_axis_tdata;
    end
    if (push) begin
      rec_q[wr_ptr_q] <= step_res.rec;
    end
  end

  // The queue never holds more than its two entries; an unknown count before the
  // first reset edge is not a violation.
  `ASTOK_ASSERT_ALWAYS(a_cnt_bound, cnt_q !== 2'd3, "event queue count out of range")
  // The second event is only selected for an entry that has one.
  `ASTOK_ASSERT(a_sel_two, (sel_q && m_axis_tvalid) |-> head.two, "second event of a single")
  // Line numbers start at one and never wrap back to zero.
  `ASTOK_ASSERT(a_line_nonzero, state_q.line != '0, "line counter reached zero")
  // End of text returns the tokenizer to its reset state.
  `ASTOK_ASSERT(a_eot_reset, (fire && (in_op_q == OP_EOT)) |=> (state_q == TOK_STATE_RST),
                "end of text did not reset the state")

endmodule

/* hw/rtl/astok_step.sv */
// Decodes one input item against the tokenizer state into its events and next state.
module astok_step (
  input  astok_pkg::tok_state_t st_i,
  input  astok_pkg::opcode_e    op_i,
  input  logic [7:0]            char_i,
  output astok_pkg::step_res_t  res_o
);
  import astok_pkg::*;

  logic [CHAR_W-1:0] c;
  logic              escaped;
  tok_state_t        nxt;
  logic              has_ev;
  ev_rec_t           rec;

  always_comb begin
    nxt     = st_i;
    has_ev  = 1'b0;
    rec     = '{two: 1'b0, kind0: EV_APPEND, char0: CH_NUL,
                kind1: EV_APPEND, char1: CH_NUL, line: st_i.line};
    c       = char_i;
    escaped = 1'b0;

    if (op_i == OP_EOT) begin
      if (st_i.token_open) begin
        has_ev    = 1'b1;
        rec.kind0 = EV_END;
      end
      nxt = TOK_STATE_RST;
    end else begin
      if (st_i.esc_pending) begin
        c               = translate_escape(char_i);
        escaped         = 1'b1;
        nxt.esc_pending = 1'b0;
      end
      if (st_i.in_quotes) begin
        if ((c == CH_BSLASH) && !escaped) begin
          nxt.esc_pending = 1'b1;
        end else begin
          has_ev         = 1'b1;
          rec.char0      = c;
          nxt.token_open = 1'b1;
          // A closing quote is appended and then ends the token.
          if ((c == CH_QUOTE) && !escaped) begin
            rec.two        = 1'b1;
            rec.kind1      = EV_END;
            nxt.token_open = 1'b0;
            nxt.in_quotes  = 1'b0;
          end
        end
      end else if (st_i.in_comment) begin
        if (c == CH_LF) begin
          nxt.in_comment = 1'b0;
        end
      end else begin
        case (c)
          CH_SEMI: begin
            nxt.in_comment = 1'b1;
          end
          CH_BSLASH: begin
            nxt.esc_pending = 1'b1;
          end
          CH_PLUS, CH_MINUS, CH_STAR: begin
            has_ev = 1'b1;
            if (st_i.token_open) begin
              rec.two   = 1'b1;
              rec.kind0 = EV_END;
              rec.char1 = c;
            end else begin
              rec.char0 = c;
            end
            nxt.token_open = 1'b1;
          end
          CH_COMMA, CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
            if (st_i.token_open) begin
              has_ev    = 1'b1;
              rec.kind0 = EV_END;
            end
            nxt.token_open = 1'b0;
            if ((c == CH_LF) && (st_i.line != '1)) begin
              nxt.line = st_i.line + LINE_BITS'(1);
            end
          end
          CH_QUOTE: begin
            nxt.in_quotes  = 1'b1;
            has_ev         = 1'b1;
            rec.char0      = c;
            nxt.token_open = 1'b1;
          end
          default: begin
            has_ev         = 1'b1;
            rec.char0      = c;
            nxt.token_open = 1'b1;
          end
        endcase
      end
    end
  end

  assign res_o = '{has_event: has_ev, rec: rec, nxt: nxt};

endmodule
